### rtl/xoro_pkg.sv
package xoro_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int IDX_W  = 7;

    // Operation codes carried in func
    localparam logic [1:0] FUNC_NEXT = 2'd0;
    localparam logic [1:0] FUNC_SEED = 2'd1;
    localparam logic [1:0] FUNC_JUMP = 2'd2;

    // SplitMix64 constants
    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL1     = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL2     = 64'h94d049bb133111eb;

    // Jump polynomial, upper word in the upper half
    localparam logic [2*WORD_W-1:0] JUMP_POLY =
        {64'h0992ccaf6a6fca05, 64'h2bd7a6a6e99c2ddc};

    // Shift and rotate amounts
    localparam int ROT_SUM = 17;
    localparam int ROT_A   = 49;
    localparam int SHL_B   = 21;
    localparam int ROT_B   = 28;
    localparam int XS1     = 30;
    localparam int XS2     = 27;
    localparam int XS3     = 31;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_NEXT_SUM,
        ST_NEXT_OUT,
        ST_SEED_ADD,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_JUMP,
        ST_JUMP_DONE
    } st_t;

    typedef struct packed {
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
    } pair_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int k);
        return (v << k) | (v >> (WORD_W - k));
    endfunction

    // One xoroshiro128 state update (no output)
    function automatic pair_t advance(input pair_t s);
        logic [WORD_W-1:0] b;
        pair_t r;
        b    = s.w1 ^ s.w0;
        r.w0 = rotl(s.w0, ROT_A) ^ b ^ (b << SHL_B);
        r.w1 = rotl(b, ROT_B);
        return r;
    endfunction

endpackage

### rtl/xoro_mul32.sv
// Registered 32x32 multiplier, shared by the three partial products of a truncated 64-bit multiply
module xoro_mul32 (
    input  logic                          clk,
    input  logic [xoro_pkg::HALF_W-1:0]   a,
    input  logic [xoro_pkg::HALF_W-1:0]   b,
    output logic [2*xoro_pkg::HALF_W-1:0] prod
);
    import xoro_pkg::*;

    logic [2*HALF_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {{HALF_W{1'b0}}, a} * {{HALF_W{1'b0}}, b};
    end

    assign prod = prod_reg;

endmodule

### rtl/xoroshiro128pp_generator_unit.sv
// Channel   Direction  Handshake             Payload
// -------   ---------  --------------------  ---------------------------
// in        input      in_valid / in_ready   func[1:0], seed_value[63:0]
// out       output     out_valid / out_ready random_value[63:0]
//
// After the accepting edge in_ready stays low while the command runs: next takes two
// adder passes; reseed two SplitMix64 rounds (one add, two 64-bit multiplies on one
// registered 32x32 multiplier); jump 128 updates plus write-back; an unused code
// leaves in_ready high. After reset the seed-zero expansion holds in_ready low.
// in_ready is high only when the sequencer is idle. A finished output sits in the
// output register; a following next waits in its last cycle until that slot is free.
module xoroshiro128pp_generator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    func,
    input  logic [xoro_pkg::WORD_W-1:0]   seed_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [xoro_pkg::WORD_W-1:0]   random_value
);
    import xoro_pkg::*;

    st_t                 state_reg, state_next;
    pair_t               s_reg, s_next;
    pair_t               acc_reg, acc_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [WORD_W-1:0]   ctr_reg, ctr_next;
    logic [WORD_W-1:0]   z_reg, z_next;
    logic [WORD_W-1:0]   mac_reg, mac_next;
    logic                word_reg, word_next;
    logic                msel_reg, msel_next;
    logic [WORD_W-1:0]   out_data_reg, out_data_next;
    logic                out_valid_reg, out_valid_next;

    logic [WORD_W-1:0]   add_a, add_b, add_sum;
    logic [HALF_W-1:0]   mul_a, mul_b;
    logic [2*HALF_W-1:0] prod;
    logic [WORD_W-1:0]   kmul;
    logic [WORD_W-1:0]   mix_word;
    logic                out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign kmul     = msel_reg ? MIX_MUL2 : MIX_MUL1;

    // Shared multiplier
    xoro_mul32 u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Partial product select: lo*lo, lo*hi, hi*lo
    always_comb
    begin
        unique case (state_reg)
            ST_MUL1:
            begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = kmul[WORD_W-1:HALF_W];
            end
            ST_MUL2:
            begin
                mul_a = z_reg[WORD_W-1:HALF_W];
                mul_b = kmul[HALF_W-1:0];
            end
            default:
            begin
                mul_a = z_reg[HALF_W-1:0];
                mul_b = kmul[HALF_W-1:0];
            end
        endcase
    end

    // Shared 64-bit adder operand select
    always_comb
    begin
        unique case (state_reg)
            ST_SEED_ADD:
            begin
                add_a = ctr_reg;
                add_b = GOLDEN_GAMMA;
            end
            ST_MUL2, ST_MUL3:
            begin
                add_a = mac_reg;
                add_b = {prod[HALF_W-1:0], {HALF_W{1'b0}}};
            end
            ST_NEXT_SUM:
            begin
                add_a = s_reg.w0;
                add_b = s_reg.w1;
            end
            ST_NEXT_OUT:
            begin
                add_a = z_reg;
                add_b = s_reg.w0;
            end
            default:
            begin
                add_a = ctr_reg;
                add_b = GOLDEN_GAMMA;
            end
        endcase
    end

    assign add_sum  = add_a + add_b;
    assign mix_word = add_sum ^ (add_sum >> XS3);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
                state_next = ST_SEED_ADD;
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func)
                        FUNC_NEXT: state_next = ST_NEXT_SUM;
                        FUNC_SEED: state_next = ST_SEED_ADD;
                        FUNC_JUMP: state_next = ST_JUMP;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_NEXT_SUM:
                state_next = ST_NEXT_OUT;
            ST_NEXT_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_SEED_ADD:
                state_next = ST_MUL0;
            ST_MUL0:
                state_next = ST_MUL1;
            ST_MUL1:
                state_next = ST_MUL2;
            ST_MUL2:
                state_next = ST_MUL3;
            ST_MUL3:
            begin
                if (!msel_reg)
                    state_next = ST_MUL0;
                else if (!word_reg)
                    state_next = ST_SEED_ADD;
                else
                    state_next = ST_IDLE;
            end
            ST_JUMP:
            begin
                if (idx_reg == {IDX_W{1'b1}})
                    state_next = ST_JUMP_DONE;
            end
            ST_JUMP_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_INIT;
        endcase
    end

    // Datapath and output updates
    always_comb
    begin
        s_next         = s_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        ctr_next       = ctr_reg;
        z_next         = z_reg;
        mac_next       = mac_reg;
        word_next      = word_reg;
        msel_next      = msel_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_INIT:
            begin
                ctr_next  = '0;
                word_next = 1'b0;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (func)
                        FUNC_SEED:
                        begin
                            ctr_next  = seed_value;
                            word_next = 1'b0;
                        end
                        FUNC_JUMP:
                        begin
                            acc_next = '0;
                            idx_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_NEXT_SUM:
                z_next = rotl(add_sum, ROT_SUM);
            ST_NEXT_OUT:
            begin
                if (out_free)
                begin
                    out_data_next  = add_sum;
                    out_valid_next = 1'b1;
                    s_next         = advance(s_reg);
                end
            end
            ST_SEED_ADD:
            begin
                ctr_next  = add_sum;
                z_next    = add_sum ^ (add_sum >> XS1);
                msel_next = 1'b0;
            end
            ST_MUL1:
                mac_next = prod;
            ST_MUL2:
                mac_next = add_sum;
            ST_MUL3:
            begin
                if (!msel_reg)
                begin
                    z_next    = add_sum ^ (add_sum >> XS2);
                    msel_next = 1'b1;
                end
                else if (!word_reg)
                begin
                    s_next.w0 = mix_word;
                    word_next = 1'b1;
                end
                else
                begin
                    s_next.w1 = mix_word;
                    // all-zero expansion is forced to a nonzero state
                    if (s_reg.w0 == '0 && mix_word == '0)
                        s_next.w0 = {{(WORD_W-1){1'b0}}, 1'b1};
                end
            end
            ST_JUMP:
            begin
                if (JUMP_POLY[idx_reg])
                    acc_next = acc_reg ^ s_reg;
                s_next   = advance(s_reg);
                idx_next = idx_reg + {{(IDX_W-1){1'b0}}, 1'b1};
            end
            ST_JUMP_DONE:
                s_next = acc_reg;
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            word_reg      <= 1'b0;
            msel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            word_reg      <= word_next;
            msel_reg      <= msel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s_reg        <= s_next;
        acc_reg      <= acc_next;
        ctr_reg      <= ctr_next;
        z_reg        <= z_next;
        mac_reg      <= mac_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign random_value = out_data_reg;

    // An idle generator never holds the all-zero state
    a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((s_reg.w0 | s_reg.w1) != '0))
        else $error("generator state is all zero while idle");

    // Jump counter rests at zero between jumps
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (idx_reg == '0))
        else $error("jump bit counter not cleared at idle");

    // Write-back follows the last polynomial bit
    a_jump_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_JUMP_DONE) |-> ($past(idx_reg) == {IDX_W{1'b1}}))
        else $error("jump ended before all polynomial bits");

    // A new output is only loaded when the output slot is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && state_reg == ST_NEXT_OUT) |=>
            (state_reg == ST_NEXT_OUT || state_reg == ST_IDLE) && out_valid_reg)
        else $error("pending output lost");

endmodule
